FILE: src/ttw_pkg.sv
// ----------------------------------------------------------------------------
// ttw_pkg
// Shared types, screen geometry and character codes of the text terminal
// writer.
// ----------------------------------------------------------------------------
package ttw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W = $clog2(CELLS);       // cell store index
    localparam int CUR_W  = $clog2(CELLS + 4);   // cursor may run up to CELLS+3
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int POS_W  = CUR_W + 1;           // working position, two's complement

    // Port field widths
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CADDR_W = 11;
    localparam int CPOS_W  = 11;
    localparam int PHASE_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [PHASE_W-1:0] {
        PH_NORMAL = 2'd0,
        PH_BG     = 2'd1,
        PH_FG     = 2'd2
    } t_phase;

    localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_S_UP  = 8'h53;
    localparam logic [CHAR_W-1:0] CH_S_LO  = 8'h73;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    // Write port of the cell store
    typedef struct packed {
        logic              we_char;
        logic              we_attr;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] chr;
        logic [ATTR_W-1:0] attr;
    } t_store_wr;

    // Outcome of one put in the character decoder
    typedef struct packed {
        logic              we_char;
        logic              we_attr;
        logic [ADDR_W-1:0] addr;
        logic [CUR_W-1:0]  base;
        logic [COL_W-1:0]  col;
        logic [ATTR_W-1:0] attr;
        t_phase            phase;
        logic              bell;
    } t_put_res;

    // {valid, nibble} of a hex digit
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

FILE: src/ttw_if.sv
// ----------------------------------------------------------------------------
// ttw_if
// Valid/ready channels of the text terminal writer: command beats in,
// result beats out.
// ----------------------------------------------------------------------------
interface ttw_cmd_if import ttw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [CHAR_W-1:0]  char_code;
    logic [CADDR_W-1:0] cell_address;

    modport source (output valid, output operation, output char_code,
                    output cell_address, input ready);
    modport sink   (input valid, input operation, input char_code,
                    input cell_address, output ready);
endinterface

interface ttw_res_if import ttw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CPOS_W-1:0]  cursor_position;
    logic               bell;
    logic [CHAR_W-1:0]  cell_char;
    logic [ATTR_W-1:0]  cell_attr;
    logic [PHASE_W-1:0] escape_phase;

    modport source (output valid, output cursor_position, output bell,
                    output cell_char, output cell_attr, output escape_phase,
                    input ready);
    modport sink   (input valid, input cursor_position, input bell,
                    input cell_char, input cell_attr, input escape_phase,
                    output ready);
endinterface

FILE: src/ttw_cell_store.sv
// ----------------------------------------------------------------------------
// ttw_cell_store
// Screen cell memory: character and attribute planes sharing one write
// address, one registered read port.
// ----------------------------------------------------------------------------
module ttw_cell_store import ttw_pkg::*; (
    input  logic              i_clk,
    input  t_store_wr         i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [CHAR_W-1:0] o_rd_char,
    output logic [ATTR_W-1:0] o_rd_attr
);

    logic [CHAR_W-1:0] r_chr [CELLS];
    logic [ATTR_W-1:0] r_att [CELLS];
    logic [CHAR_W-1:0] r_rd_char;
    logic [ATTR_W-1:0] r_rd_attr;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_char) begin
            r_chr[i_wr.addr] <= i_wr.chr;
        end
        if (i_wr.we_attr) begin
            r_att[i_wr.addr] <= i_wr.attr;
        end
        r_rd_char <= r_chr[i_rd_addr];
        r_rd_attr <= r_att[i_rd_addr];
    end

    assign o_rd_char = r_rd_char;
    assign o_rd_attr = r_rd_attr;

endmodule

FILE: src/ttw_put_unit.sv
// ----------------------------------------------------------------------------
// ttw_put_unit
// Character decoder: control codes, escape color sequence and printable
// bytes; yields the cell write and the next cursor, attribute and phase.
// ----------------------------------------------------------------------------
module ttw_put_unit import ttw_pkg::*; (
    input  logic [CHAR_W-1:0] i_char,
    input  logic [CUR_W-1:0]  i_base,
    input  logic [COL_W-1:0]  i_col,
    input  logic [ATTR_W-1:0] i_attr,
    input  t_phase            i_phase,
    output t_put_res          o_res
);

    logic [CUR_W-1:0] cur;
    logic [POS_W-1:0] pos;
    logic [COL_W:0]   col_p1;
    logic [COL_W:0]   col_p4;
    logic [4:0]       hx;
    logic             wr;
    logic             with_char;
    logic             pos_ok;

    always_comb begin
        cur       = i_base + CUR_W'(i_col);
        col_p1    = {1'b0, i_col} + (COL_W+1)'(1);
        col_p4    = {1'b0, i_col} + (COL_W+1)'(4);
        hx        = hex_digit(i_char);
        pos       = POS_W'(cur);
        wr        = 1'b0;
        with_char = 1'b0;

        o_res.base  = i_base;
        o_res.col   = i_col;
        o_res.attr  = i_attr;
        o_res.phase = i_phase;
        o_res.bell  = 1'b0;

        if (i_phase != PH_NORMAL) begin
            if (hx[4]) begin
                if (i_phase == PH_BG) begin
                    o_res.attr  = {hx[3:0], i_attr[3:0]};
                    o_res.phase = PH_FG;
                end else begin
                    o_res.attr  = {i_attr[7:4], hx[3:0]};
                    o_res.phase = PH_NORMAL;
                end
            end else if ((i_char == CH_S_LO || i_char == CH_S_UP) && i_phase == PH_BG) begin
                o_res.phase = PH_FG;
            end else begin
                o_res.phase = PH_NORMAL;
            end
        end else begin
            case (i_char)
                CH_NL: begin
                    pos        = POS_W'(i_base) + POS_W'(COLUMNS - 1);
                    wr         = 1'b1;
                    o_res.col  = '0;
                    o_res.base = i_base + CUR_W'(COLUMNS);
                end
                CH_CR: begin
                    // cell before row start; dropped on the top row
                    pos       = POS_W'(i_base) - POS_W'(1);
                    wr        = 1'b1;
                    o_res.col = '0;
                end
                CH_BS: begin
                    pos = POS_W'(cur) - POS_W'(2);
                    wr  = 1'b1;
                    // cursor - 1, held at zero
                    if (cur != '0) begin
                        if (i_col == '0) begin
                            o_res.col  = COL_W'(COLUMNS - 1);
                            o_res.base = i_base - CUR_W'(COLUMNS);
                        end else begin
                            o_res.col = i_col - COL_W'(1);
                        end
                    end
                end
                CH_TAB: begin
                    pos = POS_W'(cur) + POS_W'(3);
                    wr  = 1'b1;
                    if (col_p4 >= (COL_W+1)'(COLUMNS)) begin
                        o_res.col  = COL_W'(col_p4 - (COL_W+1)'(COLUMNS));
                        o_res.base = i_base + CUR_W'(COLUMNS);
                    end else begin
                        o_res.col = col_p4[COL_W-1:0];
                    end
                end
                CH_ESC: begin
                    o_res.phase = PH_BG;
                end
                default: begin
                    // bell writes the attribute only, anything else the char too
                    wr = 1'b1;
                    if (i_char == CH_BEL) begin
                        o_res.bell = 1'b1;
                    end else begin
                        with_char = 1'b1;
                    end
                    if (col_p1 == (COL_W+1)'(COLUMNS)) begin
                        o_res.col  = '0;
                        o_res.base = i_base + CUR_W'(COLUMNS);
                    end else begin
                        o_res.col = col_p1[COL_W-1:0];
                    end
                end
            endcase
        end

        pos_ok        = !pos[POS_W-1] && (pos < POS_W'(CELLS));
        o_res.we_attr = wr && pos_ok;
        o_res.we_char = wr && with_char && pos_ok;
        o_res.addr    = pos[ADDR_W-1:0];
    end

endmodule

FILE: src/text_mode_terminal_writer_top.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_top
// COLUMNS x ROWS text screen writer with cursor, escape color sequences,
// scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// One command beat is taken at a time and gives one result beat. After reset
// the screen memory is swept once before the first command is taken. A put
// passes S_PUT then S_DONE, a read S_READ then S_DONE, a no-op goes straight
// to S_DONE. A put that starts with the cursor past the last cell first
// scrolls the screen, which walks the cell memory once. A clear also walks
// the memory. The result register frees the command side while a result
// waits; a result only stalls the next one. blank_attribute may be written
// at any time the block is idle.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_top import ttw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata,
    ttw_cmd_if.sink           i_cmd,
    ttw_res_if.source         o_res
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_READ   = 7'b0000100,
        S_PUT    = 7'b0001000,
        S_SCROLL = 7'b0010000,
        S_FILL   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CUR_W-1:0]  r_addr, n_addr;
    logic [CUR_W-1:0]  r_base, n_base;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ATTR_W-1:0] r_attr, n_attr;
    t_phase            r_phase, n_phase;
    logic [ATTR_W-1:0] r_blank_attr, n_blank_attr;
    logic              r_out_valid, n_out_valid;

    logic [OP_W-1:0]    r_op, n_op;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_rd_ok, n_rd_ok;
    logic               r_res_bell, n_res_bell;
    logic [CHAR_W-1:0]  r_res_char, n_res_char;
    logic [ATTR_W-1:0]  r_res_attr, n_res_attr;
    logic [CPOS_W-1:0]  r_out_cursor, n_out_cursor;
    logic               r_out_bell, n_out_bell;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic [ATTR_W-1:0]  r_out_attr, n_out_attr;
    logic [PHASE_W-1:0] r_out_phase, n_out_phase;

    t_store_wr         st_wr;
    logic [ADDR_W-1:0] rd_addr;
    logic [CHAR_W-1:0] rd_char;
    logic [ATTR_W-1:0] rd_attr;
    t_put_res          put_res;
    logic [CUR_W-1:0]  cur_now;

    ttw_cell_store u_store (
        .i_clk     (i_clk),
        .i_wr      (st_wr),
        .i_rd_addr (rd_addr),
        .o_rd_char (rd_char),
        .o_rd_attr (rd_attr)
    );

    ttw_put_unit u_put (
        .i_char  (r_char),
        .i_base  (r_base),
        .i_col   (r_col),
        .i_attr  (r_attr),
        .i_phase (r_phase),
        .o_res   (put_res)
    );

    assign cur_now     = r_base + CUR_W'(r_col);
    assign i_cmd.ready = (r_state == S_IDLE);

    assign o_res.valid           = r_out_valid;
    assign o_res.cursor_position = r_out_cursor;
    assign o_res.bell            = r_out_bell;
    assign o_res.cell_char       = r_out_char;
    assign o_res.cell_attr       = r_out_attr;
    assign o_res.escape_phase    = r_out_phase;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_base       = r_base;
        n_col        = r_col;
        n_attr       = r_attr;
        n_phase      = r_phase;
        n_blank_attr = i_cfg_we ? i_cfg_wdata : r_blank_attr;
        n_out_valid  = r_out_valid && !o_res.ready;

        n_op         = r_op;
        n_char       = r_char;
        n_rd_ok      = r_rd_ok;
        n_res_bell   = r_res_bell;
        n_res_char   = r_res_char;
        n_res_attr   = r_res_attr;
        n_out_cursor = r_out_cursor;
        n_out_bell   = r_out_bell;
        n_out_char   = r_out_char;
        n_out_attr   = r_out_attr;
        n_out_phase  = r_out_phase;

        st_wr   = '0;
        rd_addr = ADDR_W'(i_cmd.cell_address);

        case (r_state)
            S_INIT: begin
                st_wr.we_char = 1'b1;
                st_wr.we_attr = 1'b1;
                st_wr.addr    = r_addr[ADDR_W-1:0];
                st_wr.chr     = CH_SPACE;
                st_wr.attr    = RESET_ATTR;
                n_addr        = r_addr + CUR_W'(1);
                if (r_addr == CUR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op       = i_cmd.operation;
                    n_char     = i_cmd.char_code;
                    n_rd_ok    = 32'(i_cmd.cell_address) < 32'(CELLS);
                    n_res_bell = 1'b0;
                    n_res_char = '0;
                    n_res_attr = '0;
                    case (i_cmd.operation)
                        OP_PUT: begin
                            if (r_base >= CUR_W'(CELLS)) begin
                                n_state = S_SCROLL;
                                n_addr  = CUR_W'(COLUMNS);
                                n_base  = r_base - CUR_W'(COLUMNS);
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                        OP_READ: begin
                            n_state = S_READ;
                        end
                        OP_CLEAR: begin
                            n_state = S_FILL;
                            n_addr  = '0;
                            n_base  = '0;
                            n_col   = '0;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_char = r_rd_ok ? rd_char : '0;
                n_res_attr = r_rd_ok ? rd_attr : '0;
                n_state    = S_DONE;
            end
            S_SCROLL: begin
                // read cell r_addr, write back the cell read last cycle one row up
                rd_addr = r_addr[ADDR_W-1:0];
                if (r_addr != CUR_W'(COLUMNS)) begin
                    st_wr.we_char = 1'b1;
                    st_wr.we_attr = 1'b1;
                    st_wr.addr    = ADDR_W'(r_addr - CUR_W'(COLUMNS + 1));
                    st_wr.chr     = rd_char;
                    st_wr.attr    = rd_attr;
                end
                n_addr = r_addr + CUR_W'(1);
                if (r_addr == CUR_W'(CELLS)) begin
                    n_state = S_FILL;
                    n_addr  = CUR_W'(CELLS - COLUMNS);
                end
            end
            S_FILL: begin
                st_wr.we_char = 1'b1;
                st_wr.we_attr = 1'b1;
                st_wr.addr    = r_addr[ADDR_W-1:0];
                st_wr.chr     = CH_SPACE;
                st_wr.attr    = r_blank_attr;
                n_addr        = r_addr + CUR_W'(1);
                if (r_addr == CUR_W'(CELLS - 1)) begin
                    n_state = (r_op == OP_CLEAR) ? S_DONE : S_PUT;
                end
            end
            S_PUT: begin
                st_wr.we_char = put_res.we_char;
                st_wr.we_attr = put_res.we_attr;
                st_wr.addr    = put_res.addr;
                st_wr.chr     = r_char;
                st_wr.attr    = r_attr;
                n_base        = put_res.base;
                n_col         = put_res.col;
                n_attr        = put_res.attr;
                n_phase       = put_res.phase;
                n_res_bell    = put_res.bell;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_cursor = CPOS_W'(cur_now);
                    n_out_bell   = r_res_bell;
                    n_out_char   = r_res_char;
                    n_out_attr   = r_res_attr;
                    n_out_phase  = r_phase;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_addr       <= '0;
            r_base       <= '0;
            r_col        <= '0;
            r_attr       <= RESET_ATTR;
            r_phase      <= PH_NORMAL;
            r_blank_attr <= RESET_ATTR;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_base       <= n_base;
            r_col        <= n_col;
            r_attr       <= n_attr;
            r_phase      <= n_phase;
            r_blank_attr <= n_blank_attr;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_char       <= n_char;
        r_rd_ok      <= n_rd_ok;
        r_res_bell   <= n_res_bell;
        r_res_char   <= n_res_char;
        r_res_attr   <= n_res_attr;
        r_out_cursor <= n_out_cursor;
        r_out_bell   <= n_out_bell;
        r_out_char   <= n_out_char;
        r_out_attr   <= n_out_attr;
        r_out_phase  <= n_out_phase;
    end

    // put with the cursor past the end must scroll first
    ap_scroll_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_cmd.valid && i_cmd.operation == OP_PUT &&
         r_base >= CUR_W'(CELLS)) |=> (r_state == S_SCROLL))
        else $error("put past end did not start a scroll");

    ap_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |-> (cur_now <= CUR_W'(CELLS + 3)))
        else $error("cursor beyond last cell plus tab overshoot");

    ap_wr_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st_wr.we_char || st_wr.we_attr) |-> (32'(st_wr.addr) < 32'(CELLS)))
        else $error("cell write outside the screen");

    ap_char_needs_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_wr.we_char |-> st_wr.we_attr)
        else $error("character written without its attribute");

    ap_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !(st_wr.we_char || st_wr.we_attr))
        else $error("cell write during read beat");

endmodule
